@@ rtl/core/xdmix_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xdmix_pkg: shared types, constants and curve table for the X-drive mixer
// Holds the response-curve ROM builder, the divider request and response
// words and the sequencer state type.
// ----------------------------------------------------------------------------
package xdmix_pkg;

  // Response curve table
  localparam int CURVE_TABLE_DEPTH = 1024;
  localparam int CURVE_IDX_W       = $clog2(CURVE_TABLE_DEPTH);
  localparam int ROM_W             = 17;  // Q16, up to and including 1.0
  localparam int CURVE_NUM_W       = CURVE_IDX_W + 7;

  // Shared divider: enough quotient bits for a table index or a 7 bit command
  localparam int DIV_STEPS = (CURVE_IDX_W > 7) ? CURVE_IDX_W : 7;
  localparam int DIV_NUM_W = (CURVE_NUM_W > 24) ? CURVE_NUM_W : 24;
  localparam int DIV_DEN_W = 17;

  // Full scale of a curve output in Q8 (127 * 256)
  localparam logic [DIV_DEN_W-1:0] FULL_Q8 = 17'd32512;

  // Configuration register indexes
  localparam logic [1:0] CFG_DEADBAND     = 2'd0;
  localparam logic [1:0] CFG_MIN_OUTPUT   = 2'd1;
  localparam logic [1:0] CFG_HEADING_GAIN = 2'd2;

  // Exponent 1 + 4915/16384 as a set of repeated square roots
  localparam logic [15:0] RootMask = 16'h6664;
  localparam logic [63:0] OneQ30   = 64'h0000_0000_4000_0000;

  typedef logic [ROM_W-1:0] curve_rom_t [CURVE_TABLE_DEPTH];

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_STEPS-1:0] quot;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CURVE,
    ST_CDIV,
    ST_ROM,
    ST_CMAG,
    ST_HOLD,
    ST_HSAT,
    ST_SUM,
    ST_MAX,
    ST_MSTART,
    ST_MDIV,
    ST_DONE
  } state_e;

  // Integer square root, one result bit per pass (elaboration only)
  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] bv;
    n   = n_in;
    res = 64'd0;
    bv  = 64'h4000_0000_0000_0000;
    for (int j = 0; j < 32; j++) begin
      if (n >= res + bv) begin
        n   = n - (res + bv);
        res = (res >> 1) + bv;
      end else begin
        res = res >> 1;
      end
      bv = bv >> 2;
    end
    return res;
  endfunction

  // Entry i is (i/(D-1))^1.3 in Q16
  function automatic curve_rom_t build_curve_rom();
    curve_rom_t  rom;
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] y;
    logic [63:0] rounded;
    for (int i = 0; i < CURVE_TABLE_DEPTH; i++) begin
      x = (64'(i) << 30) / 64'(CURVE_TABLE_DEPTH - 1);
      if (x > OneQ30) begin
        x = OneQ30;
      end
      r = x;
      y = x;
      for (int k = 1; k <= 14; k++) begin
        r = isqrt64(r << 30);
        if (RootMask[k]) begin
          y = (y * r) >> 30;
        end
      end
      rounded = (y + 64'd8192) >> 14;
      rom[i]  = rounded[ROM_W-1:0];
    end
    return rom;
  endfunction

endpackage

@@ rtl/core/x_drive_mixer_heading_hold.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x_drive_mixer_heading_hold: X-drive wheel mixer with heading hold
// Shapes three sticks through a response curve, holds heading when driving
// without turning, and mixes into four scaled wheel commands.
// ----------------------------------------------------------------------------
// One input word is taken when the block is idle; it then works on that word
// alone and raises in_stall_o until the result is handed to the output
// register. How long a word takes depends on how many sticks lie past
// their deadband and on whether the heading correction applies, and is set
// by the single shared divider, which retires one quotient bit a cycle (ten
// bits for a table index, the same ten steps for each of the four wheel
// scalings), and by the registered read of the curve ROM. The output
// register holds a finished word while the next input word is accepted.
// Configuration writes are always taken (cfg_ready_o is high) and must
// arrive only while the block is idle; an index past the register list
// is dropped.
// ----------------------------------------------------------------------------
module x_drive_mixer_heading_hold
  import xdmix_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input word
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  forward_stick_i,
  input  logic [7:0]  strafe_stick_i,
  input  logic [7:0]  rotate_stick_i,
  input  logic [23:0] heading_i,
  // result word
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  front_left_cmd_o,
  output logic [7:0]  front_right_cmd_o,
  output logic [7:0]  rear_left_cmd_o,
  output logic [7:0]  rear_right_cmd_o,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  // Curve table, read through a registered port
  localparam curve_rom_t CurveRom = build_curve_rom();

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_e               state_q, state_d;
  logic [1:0]           stick_cnt_q, stick_cnt_d;
  logic [1:0]           wheel_cnt_q, wheel_cnt_d;
  logic [7:0]           stick_q [3];
  logic [7:0]           stick_d [3];
  logic [23:0]          heading_q, heading_d;
  logic [15:0]          curve_q [3];   // forward, strafe, turn in Q8
  logic [15:0]          curve_d [3];
  logic [23:0]          target_q, target_d;
  logic                 loaded_q, loaded_d;
  logic signed [33:0]   prod_q, prod_d;
  logic [17:0]          sum_q [4];
  logic [17:0]          sum_d [4];
  logic [DIV_DEN_W-1:0] max_q, max_d;
  logic [7:0]           res_q [4];
  logic [7:0]           res_d [4];
  logic [7:0]           out_q [4];
  logic [7:0]           out_d [4];
  logic                 out_valid_q, out_valid_d;
  logic [6:0]           deadband_q;
  logic [6:0]           min_output_q;
  logic [7:0]           heading_gain_q;
  logic [ROM_W-1:0]     rom_q;

  div_req_t             div_req;
  div_rsp_t             div_rsp;

  // --------------------------------------------------------------------------
  // Curve datapath: magnitude, deadband test and table index numerator
  // --------------------------------------------------------------------------
  logic [7:0]             cur_stick;
  logic [7:0]             abs8;
  logic [6:0]             mag7;
  logic [6:0]             span;
  logic                   past_db;
  logic [CURVE_NUM_W-1:0] curve_num;
  logic [23:0]            mag_prod;
  logic [15:0]            mag_q8;
  logic [15:0]            curve_val;

  assign cur_stick = stick_q[stick_cnt_q];
  assign abs8      = cur_stick[7] ? (~cur_stick + 8'd1) : cur_stick;
  // -128 saturates to full scale
  assign mag7      = abs8[7] ? 7'd127 : abs8[6:0];
  assign span      = 7'd127 - deadband_q;
  assign past_db   = mag7 > deadband_q;
  assign curve_num = CURVE_NUM_W'(mag7 - deadband_q) * CURVE_NUM_W'(CURVE_TABLE_DEPTH - 1)
                   + CURVE_NUM_W'(span >> 1);

  // min_output + (127 - min_output) * x^1.3, all in Q8
  assign mag_prod  = 24'(7'd127 - min_output_q) * 24'(rom_q);
  assign mag_q8    = {1'b0, min_output_q, 8'd0} + 16'((mag_prod + 24'd128) >> 8);
  assign curve_val = cur_stick[7] ? (16'd0 - mag_q8) : mag_q8;

  // --------------------------------------------------------------------------
  // Heading hold: proportional correction toward the held target
  // --------------------------------------------------------------------------
  logic [23:0]        tgt_eff;
  logic signed [24:0] head_err;
  logic signed [33:0] hold_prod;
  logic [15:0]        turn_sat;

  // First word after reset holds the current heading
  assign tgt_eff   = loaded_q ? target_q : heading_q;
  assign head_err  = $signed({tgt_eff[23], tgt_eff}) - $signed({heading_q[23], heading_q});
  assign hold_prod = $signed({26'd0, heading_gain_q}) * $signed({{9{head_err[24]}}, head_err});

  always_comb begin
    if (prod_q > 34'sd32767) begin
      turn_sat = 16'h7fff;
    end else if (prod_q < -34'sd32767) begin
      turn_sat = 16'h8001;
    end else begin
      turn_sat = prod_q[15:0];
    end
  end

  // --------------------------------------------------------------------------
  // Mixer: wheel sums, common scale, truncation toward zero
  // --------------------------------------------------------------------------
  logic [17:0]          fe, se, te;
  logic [17:0]          wheel_sum;
  logic [17:0]          wheel_abs18;
  logic [DIV_DEN_W-1:0] wheel_abs;
  logic [DIV_NUM_W-1:0] mix_num;
  logic [6:0]           mix_quot;
  logic [7:0]           mix_cmd;

  assign fe = {{2{curve_q[0][15]}}, curve_q[0]};
  assign se = {{2{curve_q[1][15]}}, curve_q[1]};
  assign te = {{2{curve_q[2][15]}}, curve_q[2]};

  assign wheel_sum   = sum_q[wheel_cnt_q];
  assign wheel_abs18 = wheel_sum[17] ? (18'd0 - wheel_sum) : wheel_sum;
  assign wheel_abs   = wheel_abs18[DIV_DEN_W-1:0];
  // |sum| * 127
  assign mix_num     = (DIV_NUM_W'(wheel_abs) << 7) - DIV_NUM_W'(wheel_abs);
  assign mix_quot    = div_rsp.quot[6:0];
  assign mix_cmd     = wheel_sum[17] ? (8'd0 - {1'b0, mix_quot}) : {1'b0, mix_quot};

  // --------------------------------------------------------------------------
  // Shared divider: table index while shaping sticks, wheel scale afterwards
  // --------------------------------------------------------------------------
  xdmix_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i) begin
    rom_q <= CurveRom[div_rsp.quot[CURVE_IDX_W-1:0]];
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    stick_cnt_d = stick_cnt_q;
    wheel_cnt_d = wheel_cnt_q;
    stick_d     = stick_q;
    heading_d   = heading_q;
    curve_d     = curve_q;
    target_d    = target_q;
    loaded_d    = loaded_q;
    prod_d      = prod_q;
    sum_d       = sum_q;
    max_d       = max_q;
    res_d       = res_q;
    out_d       = out_q;
    // Drop the held word once the sink takes it
    out_valid_d = out_valid_q && out_stall_i;

    div_req.start = 1'b0;
    if (state_q == ST_MSTART) begin
      div_req.num = mix_num;
      div_req.den = max_q;
    end else begin
      div_req.num = DIV_NUM_W'(curve_num);
      div_req.den = DIV_DEN_W'(span);
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          stick_d[0]  = forward_stick_i;
          stick_d[1]  = strafe_stick_i;
          stick_d[2]  = rotate_stick_i;
          heading_d   = heading_i;
          stick_cnt_d = 2'd0;
          state_d     = ST_CURVE;
        end
      end
      ST_CURVE: begin
        if (past_db) begin
          div_req.start = 1'b1;
          state_d       = ST_CDIV;
        end else begin
          curve_d[stick_cnt_q] = 16'd0;
          stick_cnt_d          = stick_cnt_q + 2'd1;
          state_d              = (stick_cnt_q == 2'd2) ? ST_HOLD : ST_CURVE;
        end
      end
      ST_CDIV: begin
        if (div_rsp.done) begin
          state_d = ST_ROM;
        end
      end
      ST_ROM: begin
        // table word lands in rom_q at this edge
        state_d = ST_CMAG;
      end
      ST_CMAG: begin
        curve_d[stick_cnt_q] = curve_val;
        stick_cnt_d          = stick_cnt_q + 2'd1;
        state_d              = (stick_cnt_q == 2'd2) ? ST_HOLD : ST_CURVE;
      end
      ST_HOLD: begin
        loaded_d = 1'b1;
        if (curve_q[2] != 16'd0) begin
          // commanded turn: follow the robot
          target_d = heading_q;
          state_d  = ST_SUM;
        end else if (curve_q[0] != 16'd0 || curve_q[1] != 16'd0) begin
          // driving straight: correct toward the held target
          target_d = tgt_eff;
          prod_d   = hold_prod;
          state_d  = ST_HSAT;
        end else begin
          // full stop: hold wherever we are
          target_d = heading_q;
          state_d  = ST_SUM;
        end
      end
      ST_HSAT: begin
        curve_d[2] = turn_sat;
        state_d    = ST_SUM;
      end
      ST_SUM: begin
        sum_d[0]    = fe + se + te;
        sum_d[1]    = fe - se - te;
        sum_d[2]    = fe - se + te;
        sum_d[3]    = fe + se - te;
        max_d       = FULL_Q8;
        wheel_cnt_d = 2'd0;
        state_d     = ST_MAX;
      end
      ST_MAX: begin
        if (wheel_abs > max_q) begin
          max_d = wheel_abs;
        end
        wheel_cnt_d = wheel_cnt_q + 2'd1;
        if (wheel_cnt_q == 2'd3) begin
          state_d = ST_MSTART;
        end
      end
      ST_MSTART: begin
        div_req.start = 1'b1;
        state_d       = ST_MDIV;
      end
      ST_MDIV: begin
        if (div_rsp.done) begin
          res_d[wheel_cnt_q] = mix_cmd;
          wheel_cnt_d        = wheel_cnt_q + 2'd1;
          state_d            = (wheel_cnt_q == 2'd3) ? ST_DONE : ST_MSTART;
        end
      end
      ST_DONE: begin
        // Advance only once the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      stick_cnt_q <= 2'd0;
      wheel_cnt_q <= 2'd0;
      target_q    <= 24'd0;
      loaded_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stick_cnt_q <= stick_cnt_d;
      wheel_cnt_q <= wheel_cnt_d;
      target_q    <= target_d;
      loaded_q    <= loaded_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stick_q   <= stick_d;
    heading_q <= heading_d;
    curve_q   <= curve_d;
    prod_q    <= prod_d;
    sum_q     <= sum_d;
    max_q     <= max_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadband_q     <= 7'd5;
      min_output_q   <= 7'd15;
      heading_gain_q <= 8'd48;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_DEADBAND) begin
        deadband_q <= cfg_data_i[6:0];
      end
      if (cfg_index_i == CFG_MIN_OUTPUT) begin
        min_output_q <= cfg_data_i[6:0];
      end
      if (cfg_index_i == CFG_HEADING_GAIN) begin
        heading_gain_q <= cfg_data_i;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Ports
  // --------------------------------------------------------------------------
  assign in_stall_o        = (state_q != ST_IDLE);
  assign cfg_ready_o       = 1'b1;
  assign out_valid_o       = out_valid_q;
  assign front_left_cmd_o  = out_q[0];
  assign front_right_cmd_o = out_q[1];
  assign rear_left_cmd_o   = out_q[2];
  assign rear_right_cmd_o  = out_q[3];

endmodule

@@ rtl/core/xdmix_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xdmix_div: shared restoring divider
// One quotient bit per cycle; the quotient is known to fit in DIV_STEPS bits.
// ----------------------------------------------------------------------------
module xdmix_div
  import xdmix_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int CNT_W = $clog2(DIV_STEPS + 1);

  logic [DIV_DEN_W-1:0] rem_q, rem_d;
  logic [DIV_STEPS-1:0] acc_q, acc_d;
  logic [DIV_DEN_W-1:0] den_q, den_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 done_q, done_d;

  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 fits;

  assign trial = {rem_q, acc_q[DIV_STEPS-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    acc_d  = acc_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      // High part of the dividend is already below the divisor
      rem_d = DIV_DEN_W'(req_i.num >> DIV_STEPS);
      acc_d = req_i.num[DIV_STEPS-1:0];
      den_d = req_i.den;
      cnt_d = CNT_W'(DIV_STEPS);
    end else if (cnt_q != '0) begin
      rem_d  = fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      acc_d  = {acc_q[DIV_STEPS-2:0], fits};
      cnt_d  = cnt_q - CNT_W'(1);
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    acc_q <= acc_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = acc_q;

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the X-drive mixer with heading hold
// Streams stick and heading words through the mixer under random input gaps
// and output stalls, predicts every wheel word in-bench (curve table, heading
// hold, wheel scaling) and compares the four commands field by field. The
// run steps through several curve and gain settings, the extremes included.
// ----------------------------------------------------------------------------
module tb;
  import xdmix_pkg::*;

  // Index past the register list; the block must drop writes to it
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  localparam int CURVE_DEPTH = CURVE_TABLE_DEPTH;
  localparam int CURVE_LAST  = CURVE_DEPTH - 1;
  // Square-root depths 2, 5, 6, 9, 10, 13 and 14 build the 1.3 exponent
  localparam logic [15:0] ROOT_STEPS = 16'b0110_0110_0110_0100;
  localparam longint FULL_SCALE = 127 * 256;
  localparam longint HOLD_LIMIT = 32767;
  localparam int SETTLE_CYCLES = 120;  // a little past the longest latency

  typedef struct packed {
    logic [7:0]  fwd;
    logic [7:0]  strafe;
    logic [7:0]  rot;
    logic [23:0] hdg;
  } stick_word_t;

  typedef struct packed {
    logic [7:0] fl;
    logic [7:0] fr;
    logic [7:0] rl;
    logic [7:0] rr;
  } wheel_word_t;

  // --------------------------------------------------------------------------
  // Clock and block I/O; every input holds a known value from time zero
  // --------------------------------------------------------------------------
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  forward_stick_i = '0;
  logic [7:0]  strafe_stick_i = '0;
  logic [7:0]  rotate_stick_i = '0;
  logic [23:0] heading_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  front_left_cmd_o;
  logic [7:0]  front_right_cmd_o;
  logic [7:0]  rear_left_cmd_o;
  logic [7:0]  rear_right_cmd_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [7:0]  cfg_data_i = '0;

  always #10 clk_i = ~clk_i;

  x_drive_mixer_heading_hold DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .forward_stick_i   (forward_stick_i),
    .strafe_stick_i    (strafe_stick_i),
    .rotate_stick_i    (rotate_stick_i),
    .heading_i         (heading_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .front_left_cmd_o  (front_left_cmd_o),
    .front_right_cmd_o (front_right_cmd_o),
    .rear_left_cmd_o   (rear_left_cmd_o),
    .rear_right_cmd_o  (rear_right_cmd_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // Bench-side copy of the block: registers, heading target, curve table
  // --------------------------------------------------------------------------
  logic [6:0]  db_cfg = 7'd5;
  logic [6:0]  floor_cfg = 7'd15;
  logic [7:0]  gain_cfg = 8'd48;
  int          target_hdg = 0;
  bit          target_valid = 1'b0;
  logic [16:0] curve_tbl [CURVE_DEPTH];

  stick_word_t pending_q [$];       // words waiting to be driven
  wheel_word_t wheel_expect_q [$];  // predicted wheel words, oldest first
  stick_word_t sent_word;           // word currently on the input port
  int          send_gap = 0;
  int          recv_gap = 0;
  int          mismatches = 0;
  bit          calm_tail = 1'b0;    // no idling on either side once set
  logic [23:0] hdg_walk = '0;

  // Bit-serial square root; argument stays below 2^61, so 31 root bits do
  function automatic logic [63:0] q30_root(input logic [63:0] n);
    logic [63:0] acc;
    logic [63:0] trial;
    acc = '0;
    for (int b = 30; b >= 0; b--) begin
      trial = acc | (64'd1 << b);
      if (trial * trial <= n) begin
        acc = trial;
      end
    end
    return acc;
  endfunction

  // Table entry: (i / (D-1)) ^ 1.3 in Q16, built in Q30
  function automatic logic [16:0] curve_entry(input int i);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] y;
    x = (64'(i) << 30) / 64'(CURVE_LAST);
    if (x > (64'd1 << 30)) begin
      x = 64'd1 << 30;
    end
    r = x;
    y = x;
    for (int k = 1; k <= 14; k++) begin
      r = q30_root(r << 30);
      if (ROOT_STEPS[k]) begin
        y = (y * r) >> 30;
      end
    end
    return 17'((y + 64'd8192) >> 14);
  endfunction

  // Response curve in Q8, signed; -128 saturates to full magnitude
  function automatic int shaped(input logic [7:0] v);
    int sv;
    int m;
    int db;
    int fl;
    int span;
    int idx;
    int mag;
    sv = int'($signed(v));
    m  = (sv < 0) ? -sv : sv;
    db = int'(db_cfg);
    fl = int'(floor_cfg);
    if (m > 127) begin
      m = 127;
    end
    if (m <= db) begin
      return 0;
    end
    span = 127 - db;
    idx  = ((m - db) * CURVE_LAST + span / 2) / span;
    if (idx > CURVE_LAST) begin
      idx = CURVE_LAST;
    end
    mag = fl * 256 + (((127 - fl) * int'(curve_tbl[idx]) + 128) >> 8);
    return (sv < 0) ? -mag : mag;
  endfunction

  // Advance the heading target and work out the four scaled wheel commands
  function automatic wheel_word_t predict_wheels(input stick_word_t w);
    int          f;
    int          s;
    int          t;
    int          h;
    longint      corr;
    longint      peak;
    longint      mag;
    longint      sums [4];
    logic [7:0]  cmd [4];
    wheel_word_t res;
    f = shaped(w.fwd);
    s = shaped(w.strafe);
    t = shaped(w.rot);
    h = int'($signed(w.hdg));
    if (!target_valid) begin
      target_hdg   = h;
      target_valid = 1'b1;
    end
    if (t != 0) begin
      target_hdg = h;
    end else if (f != 0 || s != 0) begin
      // driving without turning: steer back toward the held heading
      corr = longint'(gain_cfg) * (longint'(target_hdg) - longint'(h));
      if (corr > HOLD_LIMIT) begin
        corr = HOLD_LIMIT;
      end
      if (corr < -HOLD_LIMIT) begin
        corr = -HOLD_LIMIT;
      end
      t = int'(corr);
    end else begin
      target_hdg = h;
    end
    sums[0] = longint'(f) + s + t;
    sums[1] = longint'(f) - s - t;
    sums[2] = longint'(f) - s + t;
    sums[3] = longint'(f) + s - t;
    peak = FULL_SCALE;
    for (int j = 0; j < 4; j++) begin
      mag = (sums[j] < 0) ? -sums[j] : sums[j];
      if (mag > peak) begin
        peak = mag;
      end
    end
    // signed division truncates toward zero
    for (int j = 0; j < 4; j++) begin
      cmd[j] = 8'((sums[j] * 127) / peak);
    end
    res.fl = cmd[0];
    res.fr = cmd[1];
    res.rl = cmd[2];
    res.rr = cmd[3];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Mix of full-range noise, values right at the deadband edge, extremes, rest
  function automatic logic [7:0] pick_stick();
    int unsigned roll;
    int          mag;
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      return 8'($urandom);
    end
    if (roll < 65) begin
      mag = int'(db_cfg) + int'($urandom_range(0, 2)) - 1;
      if (mag < 0) begin
        mag = 0;
      end
      if (mag > 127) begin
        mag = 127;
      end
      return ($urandom_range(0, 1) != 0) ? 8'(-mag) : 8'(mag);
    end
    if (roll < 85) begin
      case ($urandom_range(0, 3))
        0: return 8'h80;
        1: return 8'h81;
        2: return 8'h7F;
        default: return 8'h01;
      endcase
    end
    return 8'h00;
  endfunction

  // Mostly a slow drift so the hold loop sees small errors, now and then a jump
  function automatic logic [23:0] next_heading(input logic [23:0] last);
    case ($urandom_range(0, 19))
      0: return 24'($urandom);
      1: return 24'h80_0000;
      2: return 24'h7F_FFFF;
      default: return last + 24'($urandom_range(0, 600)) - 24'd300;
    endcase
  endfunction

  task automatic queue_word(input logic [7:0] f, input logic [7:0] s, input logic [7:0] r,
                            input logic [23:0] h);
    stick_word_t w;
    w.fwd    = f;
    w.strafe = s;
    w.rot    = r;
    w.hdg    = h;
    pending_q.push_back(w);
  endtask

  task automatic queue_random(input int count);
    for (int n = 0; n < count; n++) begin
      hdg_walk = next_heading(hdg_walk);
      // half the words carry no turn so heading hold gets exercised
      queue_word(pick_stick(), pick_stick(),
                 ($urandom_range(0, 1) != 0) ? 8'h00 : pick_stick(), hdg_walk);
    end
  endtask

  // Hold until every queued word is accepted and every wheel word is back
  task automatic wait_drained();
    do begin
      @(posedge clk_i);
    end while (pending_q.size() != 0 || in_valid_i || wheel_expect_q.size() != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_DEADBAND:     db_cfg = data[6:0];
      CFG_MIN_OUTPUT:   floor_cfg = data[6:0];
      CFG_HEADING_GAIN: gain_cfg = data;
      default: ;
    endcase
  endtask

  // Only called with the block idle; the stray index write must be dropped
  task automatic apply_setting(input logic [7:0] db, input logic [7:0] fl, input logic [7:0] g);
    write_reg(CFG_DEADBAND, db);
    write_reg(CFG_MIN_OUTPUT, fl);
    write_reg(CFG_HEADING_GAIN, g);
    write_reg(CFG_UNUSED, 8'($urandom));
  endtask

  // --------------------------------------------------------------------------
  // Driver: present one word at a time, hold it while stalled, idle in bursts
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
    end else begin
      // the word on the port is taken at this edge: predict its result now
      if (in_valid_i && !in_stall_o) begin
        wheel_expect_q.push_back(predict_wheels(sent_word));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() != 0) begin
          sent_word = pending_q.pop_front();
          forward_stick_i <= sent_word.fwd;
          strafe_stick_i  <= sent_word.strafe;
          rotate_stick_i  <= sent_word.rot;
          heading_i       <= sent_word.hdg;
          in_valid_i      <= 1'b1;
          if (!calm_tail && $urandom_range(0, 4) == 0) begin
            send_gap = $urandom_range(1, 12);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: stall in random bursts, check each accepted wheel word
  // --------------------------------------------------------------------------
  function automatic void check_cmd(input string field, input logic [7:0] want,
                                    input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $error("%s: expected %0d, actual %0d", field, $signed(want), $signed(got));
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    wheel_word_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (wheel_expect_q.size() == 0) begin
          mismatches++;
          $error("wheel word with no input word pending: %0d %0d %0d %0d",
                 $signed(front_left_cmd_o), $signed(front_right_cmd_o),
                 $signed(rear_left_cmd_o), $signed(rear_right_cmd_o));
        end else begin
          want = wheel_expect_q.pop_front();
          check_cmd("front_left_cmd", want.fl, front_left_cmd_o);
          check_cmd("front_right_cmd", want.fr, front_right_cmd_o);
          check_cmd("rear_left_cmd", want.rl, rear_left_cmd_o);
          check_cmd("rear_right_cmd", want.rr, rear_right_cmd_o);
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_stall_i <= 1'b1;
      end else if (!calm_tail && $urandom_range(0, 11) == 0) begin
        recv_gap = $urandom_range(1, 12) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < CURVE_DEPTH; i++) begin
      curve_tbl[i] = curve_entry(i);
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed words under the reset settings
    queue_word(8'sd0, 8'sd0, 8'sd0, 24'd1000);            // first word loads target
    queue_word(8'sd127, 8'sd0, 8'sd0, 24'd1000);          // drive, no error
    queue_word(8'sd127, 8'sd0, 8'sd0, 24'd1100);          // drive, small error
    queue_word(8'h80, 8'sd0, 8'sd0, 24'h80_0000);         // -128 stick, error saturates
    queue_word(8'sd0, 8'sd127, 8'sd0, 24'h7F_FFFF);       // strafe, saturates other way
    queue_word(8'sd0, 8'sd0, 8'sd127, 24'd5);             // turn reloads target
    queue_word(8'sd0, 8'sd0, 8'h80, -24'sd5);
    queue_word(8'sd5, 8'sd6, 8'sd0, -24'sd5);             // at and just past deadband
    queue_word(-8'sd127, -8'sd127, -8'sd127, 24'd0);
    queue_word(8'sd127, 8'sd127, 8'sd127, 24'd0);         // wheel sums need scaling
    queue_word(8'sd127, -8'sd127, -8'sd127, 24'd0);
    queue_word(-8'sd6, 8'sd6, 8'sd5, 24'd40);             // turn inside deadband: hold
    queue_word(8'sd0, 8'sd0, 8'sd0, 24'h7F_FFFF);         // full stop reloads target
    queue_word(8'sd64, 8'sd0, 8'sd5, 24'h80_0000);        // widest heading error
    queue_word(-8'sd1, 8'sd1, -8'sd1, 24'd123);           // everything in deadband
    queue_word(8'sd100, -8'sd50, 8'sd0, 24'd130);
    queue_word(8'sd0, -8'sd127, 8'sd0, 24'd170);
    queue_word(-8'sd64, 8'sd64, 8'sd0, -24'sd4096);
    wait_drained();

    queue_random(240);
    wait_drained();

    apply_setting(8'd0, 8'd0, 8'd0);                      // no deadband, no floor, no gain
    queue_random(110);
    wait_drained();

    apply_setting(8'hFF, 8'hFF, 8'hFF);                   // deadband 127: curve always zero
    queue_random(60);
    wait_drained();

    apply_setting(8'd126, 8'd0, 8'hFF);                   // only full stick passes
    queue_random(110);
    wait_drained();

    apply_setting(8'd0, 8'd127, 8'd1);                    // curve pinned at full scale
    queue_random(110);
    wait_drained();

    apply_setting({1'b1, 7'($urandom_range(0, 40))}, 8'($urandom), 8'($urandom));
    queue_random(150);
    wait_drained();

    // Closing stretch: no gaps, no stalls
    apply_setting({1'b0, 7'($urandom_range(0, 40))}, 8'($urandom), 8'($urandom));
    calm_tail = 1'b1;
    queue_random(150);
    wait_drained();

    // let any stray wheel word surface before the verdict
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && wheel_expect_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
